// File: hw/rtl/hof_pkg.sv
// Package with payload types and fixed widths for the outlier filter.
`timescale 1ns / 1ps
package hof_pkg;
    localparam int unsigned ChannelWidth = 4;
    localparam int unsigned SampleWidth  = 16;
    localparam int unsigned GainWidth    = 8;
    localparam logic [GainWidth-1:0] GainReset = 8'd48;

    typedef struct packed {
        logic [ChannelWidth-1:0]       channel;
        logic signed [SampleWidth-1:0] sample;
    } in_word_t;

    typedef struct packed {
        logic signed [SampleWidth-1:0] filtered;
        logic                          replaced;
        logic signed [SampleWidth-1:0] window_median;
    } out_word_t;
endpackage

// File: hw/rtl/hof_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module hof_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 96
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

// File: hw/rtl/hampel_outlier_filter_unit.sv
// Top level of the multi-channel Hampel outlier filter.
//
//  channel   direction  handshake            payload
//  in        input      in_valid/in_stall    hof_pkg::in_word_t
//  out       output     out_valid/out_stall  hof_pkg::out_word_t
//  cfg       input      cfg_we               outlier_gain (8 bits)
//
// An in-range word goes through two rank-selection passes, for the median and for the median
// absolute deviation; for each of the n candidates, where n is the channel's fill count after
// the write, a pass reads all n entries through the single read port, one compare per cycle.
// A word for a channel past the last one goes straight to the output register. Reset clears
// the fill counts and pointers and sets the gain to GainReset; the window RAM needs no clearing.
// While the output word is stalled, an in-range input word is still taken and processed and
// then waits for the output register; a word for a channel past the last one is held off.
`timescale 1ns / 1ps
module hampel_outlier_filter_unit #(
    parameter int unsigned WINDOW   = 8,
    parameter int unsigned CHANNELS = 12
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  hof_pkg::in_word_t    in_word,
    output logic                 out_valid,
    input  logic                 out_stall,
    output hof_pkg::out_word_t   out_word,
    input  logic                 cfg_we,
    input  logic [7:0]           cfg_data
);
    import hof_pkg::*;

    localparam int unsigned IW = $clog2(WINDOW);
    localparam int unsigned NW = $clog2(WINDOW + 1);
    localparam int unsigned CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int unsigned DEPTH = CHANNELS * WINDOW;
    localparam int unsigned AW = $clog2(DEPTH);

    typedef enum logic [2:0] {
        S_IDLE, S_OUTER, S_INNER_A, S_INNER_B, S_PICK, S_DECIDE, S_OUT
    } state_t;

    state_t state_reg;
    logic [GainWidth-1:0] gain_reg;
    logic [IW-1:0] wptr_reg [CHANNELS];
    logic [NW-1:0] fill_reg [CHANNELS];
    logic [CW-1:0] ch_reg;
    logic signed [SampleWidth-1:0] x_reg;
    logic [NW-1:0] n_reg;
    logic pass_reg;
    logic [IW-1:0] i_reg, j_reg;
    logic signed [17:0] cand_reg, cur_reg;
    logic [NW-1:0] less_reg, leq_reg;
    logic signed [17:0] lo_reg, hi_reg;
    logic got_lo_reg, got_hi_reg;
    logic signed [17:0] med_reg, mad_reg;
    out_word_t out_reg;
    logic out_valid_reg;

    logic ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [SampleWidth-1:0] ram_rdata;
    logic [IW-1:0] rd_idx;
    logic signed [17:0] elem;
    logic [NW-1:0] k_lo, k_hi;
    logic in_range;
    logic [CW-1:0] in_ch;
    logic signed [17:0] dx;
    logic [17:0] dx_abs;
    logic [20:0] lhs;
    logic [25:0] rhs;
    logic signed [18:0] mid_sum;
    logic outlier;
    logic out_load;

    hof_ram #(.WIDTH(SampleWidth), .DEPTH(DEPTH)) u_window (
        .clk(clk), .wr_en(ram_we), .wr_addr(ram_waddr), .wr_data(in_word.sample),
        .rd_addr(ram_raddr), .rd_data(ram_rdata)
    );

    assign in_range = (32'(in_word.channel) < CHANNELS);
    assign in_ch = in_range ? CW'(in_word.channel) : '0;
    assign in_stall = (state_reg != S_IDLE) || (out_valid_reg && out_stall && !in_range);
    assign ram_we = in_valid && !in_stall && in_range;
    assign ram_waddr = AW'(in_ch * WINDOW + wptr_reg[in_ch]);
    assign rd_idx = (state_reg == S_OUTER) ? i_reg : j_reg;
    assign ram_raddr = AW'(ch_reg * WINDOW + rd_idx);
    assign elem = pass_reg ? ((18'(signed'(ram_rdata)) - med_reg) < 0
                              ? med_reg - 18'(signed'(ram_rdata))
                              : 18'(signed'(ram_rdata)) - med_reg)
                           : 18'(signed'(ram_rdata));
    // Ranks of the middle elements: lower (n-1)/2, upper n/2.
    assign k_lo = (n_reg - 1'b1) >> 1;
    assign k_hi = n_reg >> 1;
    assign mid_sum = 19'(lo_reg) + 19'(hi_reg);
    assign dx = 18'(x_reg) - med_reg;
    assign dx_abs = (dx < 0) ? 18'(-dx) : 18'(dx);
    assign lhs = {dx_abs[16:0], 4'b0} ;
    assign rhs = 26'(gain_reg) * 26'(mad_reg[16:0]);
    assign outlier = (26'(lhs) > rhs);
    assign out_load = (state_reg == S_IDLE && in_valid && !in_stall && !in_range)
                      || (state_reg == S_OUT && !out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            gain_reg      <= GainReset;
            out_valid_reg <= 1'b0;
            for (int c = 0; c < CHANNELS; c++)
            begin
                wptr_reg[c] <= '0;
                fill_reg[c] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                gain_reg <= cfg_data;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && !in_stall)
                    begin
                        x_reg <= in_word.sample;
                        ch_reg <= in_ch;
                        if (!in_range)
                        begin
                            out_reg <= '{filtered: in_word.sample, replaced: 1'b0,
                                         window_median: '0};
                        end
                        else
                        begin
                            wptr_reg[in_ch] <= (32'(wptr_reg[in_ch]) == WINDOW - 1)
                                               ? '0 : wptr_reg[in_ch] + 1'b1;
                            if (32'(fill_reg[in_ch]) < WINDOW)
                            begin
                                fill_reg[in_ch] <= fill_reg[in_ch] + 1'b1;
                                n_reg <= fill_reg[in_ch] + 1'b1;
                            end
                            else
                            begin
                                n_reg <= fill_reg[in_ch];
                            end
                            pass_reg   <= 1'b0;
                            i_reg      <= '0;
                            got_lo_reg <= 1'b0;
                            got_hi_reg <= 1'b0;
                            state_reg  <= S_OUTER;
                        end
                    end
                end
                S_OUTER:
                begin
                    // Read of candidate i is issued; data arrives next cycle.
                    j_reg     <= '0;
                    state_reg <= S_INNER_A;
                end
                S_INNER_A:
                begin
                    cand_reg  <= elem;
                    less_reg  <= '0;
                    leq_reg   <= '0;
                    state_reg <= S_INNER_B;
                    j_reg     <= j_reg + 1'b1;
                end
                S_INNER_B:
                begin
                    // elem is entry j-1 here; j_reg points one ahead.
                    if (elem < cand_reg)
                    begin
                        less_reg <= less_reg + 1'b1;
                    end
                    if (elem <= cand_reg)
                    begin
                        leq_reg <= leq_reg + 1'b1;
                    end
                    if (32'(j_reg) == 32'(n_reg) || j_reg == '0)
                    begin
                        state_reg <= S_PICK;
                    end
                    else
                    begin
                        j_reg <= j_reg + 1'b1;
                    end
                end
                S_PICK:
                begin
                    if (less_reg <= k_lo && leq_reg > k_lo)
                    begin
                        lo_reg <= cand_reg;
                        got_lo_reg <= 1'b1;
                    end
                    if (less_reg <= k_hi && leq_reg > k_hi)
                    begin
                        hi_reg <= cand_reg;
                        got_hi_reg <= 1'b1;
                    end
                    if (32'(i_reg) + 1 == 32'(n_reg))
                    begin
                        state_reg <= S_DECIDE;
                    end
                    else
                    begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= S_OUTER;
                    end
                end
                S_DECIDE:
                begin
                    if (!pass_reg)
                    begin
                        med_reg    <= 18'(mid_sum >>> 1);
                        pass_reg   <= 1'b1;
                        i_reg      <= '0;
                        got_lo_reg <= 1'b0;
                        got_hi_reg <= 1'b0;
                        state_reg  <= S_OUTER;
                    end
                    else
                    begin
                        mad_reg   <= 18'(mid_sum >>> 1);
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (!out_valid_reg)
                    begin
                        out_reg   <= '{filtered: outlier ? SampleWidth'(med_reg) : x_reg,
                                       replaced: outlier,
                                       window_median: SampleWidth'(med_reg)};
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_word))
        else $error("output word changed while stalled");
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> in_stall)
        else $error("input taken while busy");
    a_pick_found: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DECIDE |-> got_lo_reg && got_hi_reg)
        else $error("median rank not found");
endmodule

// File: verif/tb.sv
// Self-checking testbench for the multi-channel Hampel outlier filter.
`timescale 1ns / 1ps
module tb;
    import hof_pkg::*;

    localparam int Window = 8;
    localparam int Channels = 12;
    localparam int RandomWords = 1100;
    localparam int WordLatency = 160;
    localparam int HoldCycles = 3000;

    typedef struct {
        logic [3:0]  channel;
        logic [15:0] sample;
        logic        typed;
        logic [15:0] filtered;
        logic        replaced;
        logic [15:0] window_median;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    in_word_t in_word = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    out_word_t out_word;
    logic cfg_we = 1'b0;
    logic [7:0] cfg_data = '0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    logic hold_go = 1'b0;
    int hold_count = 0;
    int errors = 0;
    out_word_t pending_words[$];
    stim_row_t directed_rows[$];

    logic [7:0] gain_model;
    int window_model[Channels][Window];
    int pointer_model[Channels];
    int count_model[Channels];

    hampel_outlier_filter_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
        .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
        .cfg_we(cfg_we), .cfg_data(cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        #20ms;
        $display("hampel_outlier_filter_unit test failed");
        $finish;
    end

    function automatic int median_sorted(int v[Window], int n);
        int key;
        int j;
        int s;
        for (int i = 1; i < n; i++)
        begin
            key = v[i];
            j = i;
            while (j > 0 && v[j-1] > key)
            begin
                v[j] = v[j-1];
                j--;
            end
            v[j] = key;
        end
        if (n % 2 == 0)
        begin
            s = v[n/2] + v[n/2-1];
            return s >>> 1;
        end
        return v[n/2];
    endfunction

    function automatic out_word_t filter_sample(logic [3:0] ch, logic [15:0] raw);
        out_word_t r;
        int x;
        int w[Window];
        int n;
        int med;
        int mad;
        int dx;
        x = $signed(raw);
        r = '0;
        if (ch >= Channels)
        begin
            r.filtered = raw;
            return r;
        end
        window_model[ch][pointer_model[ch]] = x;
        pointer_model[ch] = (pointer_model[ch] + 1) % Window;
        if (count_model[ch] < Window)
            count_model[ch]++;
        n = count_model[ch];
        for (int i = 0; i < Window; i++)
            w[i] = (i < n) ? window_model[ch][i] : 0;
        med = median_sorted(w, n);
        for (int i = 0; i < Window; i++)
            w[i] = (i < n) ? ((window_model[ch][i] > med) ? window_model[ch][i] - med
                                                          : med - window_model[ch][i]) : 0;
        mad = median_sorted(w, n);
        dx = (x > med) ? x - med : med - x;
        r.replaced = (longint'(dx) * 16) > (longint'(gain_model) * mad);
        r.filtered = r.replaced ? 16'(med) : raw;
        r.window_median = 16'(med);
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch in %s: got %0d, expected %0d", what, got, want);
        errors++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_words.size() == 0)
                report_mismatch("unexpected word", 1, 0);
            else
            begin
                out_word_t e;
                e = pending_words.pop_front();
                if (out_word.filtered !== e.filtered)
                    report_mismatch("filtered", $signed(out_word.filtered), $signed(e.filtered));
                if (out_word.replaced !== e.replaced)
                    report_mismatch("replaced", out_word.replaced, e.replaced);
                if (out_word.window_median !== e.window_median)
                    report_mismatch("window_median", $signed(out_word.window_median),
                                    $signed(e.window_median));
            end
        end
    end

    always @(negedge clk)
    begin
        if (hold_go && hold_count < HoldCycles)
        begin
            out_stall <= 1'b1;
            hold_count <= hold_count + 1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    task automatic send_word(logic [3:0] ch, logic [15:0] s, out_word_t want);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_word <= '{channel: ch, sample: s};
        pending_words.insert(pending_words.size(), want);
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_checked(logic [3:0] ch, logic [15:0] s);
        send_word(ch, s, filter_sample(ch, s));
    endtask

    task automatic drain_outputs();
        in_valid <= 1'b0;
        while (pending_words.size() != 0)
            @(negedge clk);
        repeat (WordLatency) @(negedge clk);
    endtask

    task automatic write_gain(logic [7:0] g);
        cfg_we <= 1'b1;
        cfg_data <= g;
        @(negedge clk);
        cfg_we <= 1'b0;
        gain_model = g;
    endtask

    task automatic add_row(logic [3:0] ch, logic [15:0] s, logic typed, logic [15:0] f,
                           logic rep, logic [15:0] m);
        stim_row_t r;
        r.channel = ch;
        r.sample = s;
        r.typed = typed;
        r.filtered = f;
        r.replaced = rep;
        r.window_median = m;
        directed_rows.insert(directed_rows.size(), r);
    endtask

    task automatic random_phase(int words, logic [7:0] g);
        logic [3:0] ch;
        logic [15:0] s;
        int base;
        write_gain(g);
        for (int i = 0; i < words; i++)
        begin
            ch = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 12))
                                           : 4'($urandom_range(Channels - 1));
            base = $signed(16'(ch * 1000));
            case ($urandom_range(3))
                0: s = 16'($urandom);
                1: s = 16'(base + $urandom_range(64) - 32);
                2: s = ($urandom_range(1)) ? 16'h7fff : 16'h8000;
                default: s = 16'(base + $urandom_range(4000) - 2000);
            endcase
            send_checked(ch, s);
        end
        drain_outputs();
    endtask

    initial
    begin
        gain_model = GainReset;
        for (int c = 0; c < Channels; c++)
        begin
            pointer_model[c] = 0;
            count_model[c] = 0;
        end
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // First word of a channel is its own median, never replaced.
        add_row(4'd0, 16'h7fff, 1'b1, 16'h7fff, 1'b0, 16'h7fff);
        add_row(4'd1, 16'h8000, 1'b1, 16'h8000, 1'b0, 16'h8000);
        // Channels past the last one pass the sample through.
        add_row(4'd12, 16'h1234, 1'b1, 16'h1234, 1'b0, 16'h0000);
        add_row(4'd15, 16'hffff, 1'b1, 16'hffff, 1'b0, 16'h0000);
        add_row(4'd0, 16'h8000, 1'b0, '0, 1'b0, '0);
        add_row(4'd1, 16'h7fff, 1'b0, '0, 1'b0, '0);
        for (int i = 0; i < 9; i++)
            add_row(4'd2, 16'(i * 3 - 5), 1'b0, '0, 1'b0, '0);
        add_row(4'd2, 16'h7fff, 1'b0, '0, 1'b0, '0);
        add_row(4'd2, 16'h8000, 1'b0, '0, 1'b0, '0);
        add_row(4'd2, 16'hffff, 1'b0, '0, 1'b0, '0);
        add_row(4'd11, 16'h5555, 1'b0, '0, 1'b0, '0);
        add_row(4'd11, 16'haaaa, 1'b0, '0, 1'b0, '0);
        add_row(4'd11, 16'haaab, 1'b0, '0, 1'b0, '0);
        foreach (directed_rows[i])
        begin
            out_word_t w;
            w = filter_sample(directed_rows[i].channel, directed_rows[i].sample);
            if (directed_rows[i].typed)
            begin
                w.filtered = directed_rows[i].filtered;
                w.replaced = directed_rows[i].replaced;
                w.window_median = directed_rows[i].window_median;
            end
            send_word(directed_rows[i].channel, directed_rows[i].sample, w);
        end
        drain_outputs();

        send_idle_pct = 25;
        recv_idle_pct = 52;
        random_phase(350, 8'd0);
        hold_go = 1'b1;
        random_phase(30, 8'd255);
        send_idle_pct = 52;
        recv_idle_pct = 25;
        random_phase(350, 8'd16);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(370, 8'd48);

        if (errors == 0)
            $display("hampel_outlier_filter_unit test passed");
        else
            $display("hampel_outlier_filter_unit test failed");
        $finish;
    end
endmodule

// File: filelist.f
hw/rtl/hof_pkg.sv
hw/rtl/hof_ram.sv
hw/rtl/hampel_outlier_filter_unit.sv
verif/tb.sv
